/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pidl_pkg.sv */
// Package with the shared sizes, codes and cell command type of the list core.
`default_nettype none

package pidl_pkg;

    // Number of element cells in the list.
    localparam int CAPACITY = 16;

    // Field widths of the words on the two channels.
    localparam int KIND_W  = 2;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;

    // Internal widths derived from the capacity.
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W   = $clog2(CAPACITY + 1);
    localparam int COMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    // Capacity as seen on the count output.
    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    // Operation codes.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the chain at once.
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic                     clr;
        logic                     pick;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

`default_nettype wire

/* hdl/pidl_cell.sv */
// One storage cell of the list chain, shifting with its neighbors.
`default_nettype none

module pidl_cell (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pidl_pkg::t_cell_cmd                i_cmd,
    input  wire logic [pidl_pkg::IDX_W-1:0]         i_idx,
    input  wire logic signed [pidl_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [pidl_pkg::DATA_W-1:0] i_right,
    output logic signed [pidl_pkg::DATA_W-1:0]      o_data,
    output logic signed [pidl_pkg::DATA_W-1:0]      o_pick
);

    logic signed [pidl_pkg::DATA_W-1:0] r_data;
    logic signed [pidl_pkg::DATA_W-1:0] n_data;
    logic                               w_below;
    logic                               w_here;

    assign w_below = (i_idx < i_cmd.index);
    assign w_here  = (i_idx == i_cmd.index);

    // Ins/del move cells from the target up one place; clr zeroes all.
    always_comb begin
        n_data = r_data;
        if (i_cmd.clr) begin
            n_data = '0;
        end else if (i_cmd.ins && !w_below) begin
            n_data = w_here ? i_cmd.value : i_left;
        end else if (i_cmd.del && !w_below) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;
    assign o_pick = (i_cmd.pick && w_here) ? r_data : '0;

endmodule

`default_nettype wire

/* hdl/pidl_ctrl.sv */
// Decoder that checks an operation against the length and builds the cell command.
`default_nettype none

module pidl_ctrl (
    input  wire logic                               i_go,
    input  wire logic [pidl_pkg::KIND_W-1:0]        i_kind,
    input  wire logic [pidl_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [pidl_pkg::DATA_W-1:0] i_value,
    input  wire logic [pidl_pkg::LEN_W-1:0]         i_length,
    output pidl_pkg::t_cell_cmd                     o_cmd,
    output logic [pidl_pkg::STAT_W-1:0]             o_status,
    output logic [pidl_pkg::LEN_W-1:0]              o_length
);

    logic [pidl_pkg::COMP_W-1:0] w_pos;
    logic [pidl_pkg::COMP_W-1:0] w_len;
    logic                        w_ins_ok;
    logic                        w_acc_ok;
    logic                        w_full;

    assign w_pos    = pidl_pkg::COMP_W'(i_position);
    assign w_len    = pidl_pkg::COMP_W'(i_length);
    assign w_ins_ok = (w_pos != '0) && (w_pos <= w_len + pidl_pkg::COMP_W'(1));
    assign w_acc_ok = (w_pos != '0) && (w_pos <= w_len);
    assign w_full   = (i_length >= pidl_pkg::LEN_W'(pidl_pkg::CAPACITY));

    always_comb begin
        o_cmd       = '0;
        o_cmd.index = pidl_pkg::IDX_W'(i_position - pidl_pkg::POS_W'(1));
        o_cmd.value = i_value;
        o_status    = pidl_pkg::ST_OK;
        o_length    = i_length;
        case (i_kind)
            pidl_pkg::KIND_INSERT: begin
                if (!w_ins_ok) begin
                    o_status = pidl_pkg::ST_RANGE;
                end else if (w_full) begin
                    o_status = pidl_pkg::ST_FULL;
                end else begin
                    o_cmd.ins = i_go;
                    o_length  = i_length + pidl_pkg::LEN_W'(1);
                end
            end
            pidl_pkg::KIND_DELETE: begin
                if (!w_acc_ok) begin
                    o_status = pidl_pkg::ST_RANGE;
                end else begin
                    o_cmd.del  = i_go;
                    o_cmd.pick = 1'b1;
                    o_length   = i_length - pidl_pkg::LEN_W'(1);
                end
            end
            pidl_pkg::KIND_READ: begin
                if (!w_acc_ok) begin
                    o_status = pidl_pkg::ST_RANGE;
                end else begin
                    o_cmd.pick = 1'b1;
                end
            end
            default: begin
                o_cmd.clr = i_go;
                o_length  = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/positional_insert_delete_list_core.sv */
// Top level of the positional insert/delete list core.
// This core keeps an ordered list of up to sixteen signed 32-bit elements in
// a chain of identical cells, addressed by one-based position. Each input word
// asks to insert a value at a position, delete the element at a position, read
// the element at a position, or clear the list, and every word yields exactly
// one result word carrying a status (ok, position out of range, or list full),
// the removed or read element (zero otherwise), and the element count after
// the operation. An insert or delete moves every cell from the target upward
// by one place together, because each cell loads from its neighbor at once, so
// the core accepts one input word per clock cycle and presents its result in
// the cycle after acceptance in an output register. That register lets a new
// word enter in the same cycle in which the waiting result is taken, so the
// input only stalls while a result sits unclaimed. Reset clears every cell and
// the length directly, so no clearing pass follows reset.
`default_nettype none

module positional_insert_delete_list_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [pidl_pkg::KIND_W-1:0]        i_kind,
    input  wire logic [pidl_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [pidl_pkg::DATA_W-1:0] i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [pidl_pkg::STAT_W-1:0]             o_status,
    output logic signed [pidl_pkg::DATA_W-1:0]      o_value_out,
    output logic [pidl_pkg::CNT_W-1:0]              o_count_after
);

    // Length of the list and the registered result word.
    logic [pidl_pkg::LEN_W-1:0]         r_length;
    logic [pidl_pkg::LEN_W-1:0]         n_length;
    logic                               r_out_valid;
    logic [pidl_pkg::STAT_W-1:0]        r_status;
    logic [pidl_pkg::STAT_W-1:0]        n_status;
    logic signed [pidl_pkg::DATA_W-1:0] r_value_out;
    logic signed [pidl_pkg::DATA_W-1:0] n_value_out;
    logic [pidl_pkg::CNT_W-1:0]         r_count;

    logic                               w_accept;
    pidl_pkg::t_cell_cmd                w_cmd;

    // Per-cell neighbor links and picked words.
    logic signed [pidl_pkg::DATA_W-1:0] w_data  [pidl_pkg::CAPACITY];
    logic signed [pidl_pkg::DATA_W-1:0] w_pick  [pidl_pkg::CAPACITY];
    logic signed [pidl_pkg::DATA_W-1:0] w_left  [pidl_pkg::CAPACITY];
    logic signed [pidl_pkg::DATA_W-1:0] w_right [pidl_pkg::CAPACITY];

    // A new word may enter when the result register is empty or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // The decoder checks the position against the current length and only
    // enables the cells when the word is actually accepted.
    pidl_ctrl u_ctrl (
        .i_go       (w_accept),
        .i_kind     (i_kind),
        .i_position (i_position),
        .i_value    (i_value),
        .i_length   (r_length),
        .o_cmd      (w_cmd),
        .o_status   (n_status),
        .o_length   (n_length)
    );

    // The chain: cell zero holds position one. An insert pulls from the left
    // neighbor, a delete from the right one; the top cell takes zero on delete.
    for (genvar gi = 0; gi < pidl_pkg::CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_left[gi] = '0;
        end else begin : g_inner_l
            assign w_left[gi] = w_data[gi-1];
        end
        if (gi == pidl_pkg::CAPACITY - 1) begin : g_last
            assign w_right[gi] = '0;
        end else begin : g_inner_r
            assign w_right[gi] = w_data[gi+1];
        end

        pidl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_idx   (pidl_pkg::IDX_W'(gi)),
            .i_left  (w_left[gi]),
            .i_right (w_right[gi]),
            .o_data  (w_data[gi]),
            .o_pick  (w_pick[gi])
        );
    end

    // At most one cell drives a nonzero picked word, so an OR gathers it.
    always_comb begin
        n_value_out = '0;
        for (int k = 0; k < pidl_pkg::CAPACITY; k++) begin
            n_value_out = n_value_out | w_pick[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_length    <= n_length;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload loads with each accepted word and needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_value_out <= n_value_out;
            r_count     <= pidl_pkg::CNT_W'(n_length);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_value_out   = r_value_out;
    assign o_count_after = r_count;

endmodule

`default_nettype wire

/* hdl/pidl_checker.sv */
// Port-level checker for the list core and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module pidl_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic [pidl_pkg::STAT_W-1:0]        i_status,
    input  wire logic signed [pidl_pkg::DATA_W-1:0] i_value_out,
    input  wire logic [pidl_pkg::CNT_W-1:0]         i_count_after
);

    logic                                                          w_stall;
    logic [pidl_pkg::STAT_W+pidl_pkg::DATA_W+pidl_pkg::CNT_W-1:0] w_payload;
    logic                                                          w_refused_ok;
    logic                                                          w_full_st;
    logic                                                          w_at_cap;
    logic                                                          w_legal;

    assign w_stall      = i_out_valid && !i_out_ready;
    assign w_payload    = {i_status, i_value_out, i_count_after};
    assign w_refused_ok = !(i_out_valid && (i_status != pidl_pkg::ST_OK))
                          || (i_value_out == '0);
    assign w_full_st    = i_out_valid && (i_status == pidl_pkg::ST_FULL);
    assign w_at_cap     = (i_count_after == pidl_pkg::CAP_COUNT);
    assign w_legal      = (i_count_after <= pidl_pkg::CAP_COUNT)
                          && ((i_status == pidl_pkg::ST_OK)
                              || (i_status == pidl_pkg::ST_RANGE)
                              || (i_status == pidl_pkg::ST_FULL));

    // A result that is not taken stays on the port unchanged.
    `ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, w_stall, i_out_valid, "stalled word dropped")
    `ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, w_stall, $stable(w_payload), "stalled word changed")

    // Refused operations never return an element.
    `ASSERT_ALWAYS(a_refused_zero, i_clk, i_rst_n, w_refused_ok, "refusal returned a value")

    // A full refusal can only happen at capacity.
    `ASSERT_IMPLIES(a_full_count, i_clk, i_rst_n, w_full_st, w_at_cap, "full below capacity")

    // Only the defined status codes appear, and the count never exceeds the capacity.
    `ASSERT_IMPLIES(a_legal, i_clk, i_rst_n, i_out_valid, w_legal, "illegal status or count")

endmodule

bind positional_insert_delete_list_core pidl_checker u_pidl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .i_status      (o_status),
    .i_value_out   (o_value_out),
    .i_count_after (o_count_after)
);

`default_nettype wire
